FILE: design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the subset sum matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int ITEM_BITS   = 32;
	localparam int TARGET_BITS = 36;
	localparam int MASK_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int LOADED_W    = 3;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SEARCH,
		ST_FINISH
	} ssm_state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic finish;
	} ssm_cmd_t;

	typedef struct packed {
		logic hit;
		logic last_mask;
		logic pend_valid;
		logic out_free;
	} ssm_stat_t;

endpackage

FILE: design/ssm_item_if.sv
// ----------------------------------------------------------------------------
// ssm_item_if
// Input channel: one set element per item.
// ----------------------------------------------------------------------------
interface ssm_item_if import ssm_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [ITEM_BITS-1:0] item_value;
	logic                        is_last;

	modport source (output valid, output item_value, output is_last, input ready);
	modport sink   (input valid, input item_value, input is_last, output ready);
endinterface

FILE: design/ssm_result_if.sv
// ----------------------------------------------------------------------------
// ssm_result_if
// Output channel: one match report per item.
// ----------------------------------------------------------------------------
interface ssm_result_if import ssm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  subset_mask;
	logic               found;
	logic [COUNT_W-1:0] match_count;
	logic               too_many;
	logic               last_result;

	modport source (output valid, output subset_mask, output found, output match_count,
		output too_many, output last_result, input ready);
	modport sink   (input valid, input subset_mask, input found, input match_count,
		input too_many, input last_result, output ready);
endinterface

FILE: design/ssm_cfg_if.sv
// ----------------------------------------------------------------------------
// ssm_cfg_if
// Configuration write channel for the target sum register.
// ----------------------------------------------------------------------------
interface ssm_cfg_if import ssm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [TARGET_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl
// Controller: load phase, subset walk with output stall, final report.
// ----------------------------------------------------------------------------
module ssm_ctrl import ssm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_is_last,
	output logic      in_ready,
	output ssm_cmd_t  cmd,
	input  ssm_stat_t stat
);

	ssm_state_t state_q;
	ssm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_is_last) begin
						cmd.start = 1'b1;
						state_d   = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				// hold while a second match waits for the output slot
				cmd.step = !(stat.hit && stat.pend_valid && !stat.out_free);
				if (cmd.step && stat.last_mask) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

FILE: design/ssm_datapath.sv
// ----------------------------------------------------------------------------
// ssm_datapath
// Step store, running subset sum in binary mask order, pending match and
// output register.
// ----------------------------------------------------------------------------
module ssm_datapath import ssm_pkg::*; #(
	parameter int MAX_ITEMS  = 6,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssm_cmd_t                    cmd,
	output ssm_stat_t                   stat,
	input  logic signed [ITEM_BITS-1:0] item_value,
	ssm_cfg_if.sink                     cfg,
	ssm_result_if.source                results
);

	localparam int SUM_W = VALUE_BITS + 3;

	logic signed [TARGET_BITS-1:0] target_q;
	logic        [SUM_W-1:0]       delta_q [MAX_ITEMS];
	logic        [SUM_W-1:0]       prefix_q;
	logic        [LOADED_W-1:0]    loaded_q;
	logic                          ovf_q;
	logic        [MASK_W-1:0]      mask_q;
	logic        [SUM_W-1:0]       sum_q;
	logic        [COUNT_W-1:0]     count_q;
	logic                          pend_valid_q;
	logic        [MASK_W-1:0]      pend_mask_q;
	logic        [COUNT_W-1:0]     pend_count_q;

	logic                          out_valid_q;
	logic        [MASK_W-1:0]      out_mask_q;
	logic                          out_found_q;
	logic        [COUNT_W-1:0]     out_count_q;
	logic                          out_too_many_q;
	logic                          out_last_q;

	logic        [SUM_W-1:0]       value_ext;
	logic        [SUM_W-1:0]       step_delta;
	logic                          step_sel_done;
	logic        [MASK_W-1:0]      full_mask;
	logic signed [TARGET_BITS-1:0] sum_ext;
	logic                          store_room;
	logic                          push_pend;

	assign value_ext  = {{3{item_value[VALUE_BITS-1]}}, item_value[VALUE_BITS-1:0]};
	assign sum_ext    = {{(TARGET_BITS-SUM_W){sum_q[SUM_W-1]}}, sum_q};
	assign full_mask  = MASK_W'((COUNT_W'(1) << loaded_q) - COUNT_W'(1));
	assign store_room = loaded_q < LOADED_W'(MAX_ITEMS);

	assign stat.hit        = sum_ext == target_q;
	assign stat.last_mask  = mask_q == full_mask;
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = !out_valid_q || results.ready;

	assign push_pend = cmd.step && stat.hit && pend_valid_q;

	// next mask sets the lowest clear bit and clears the ones below it
	always_comb begin
		step_delta    = delta_q[0];
		step_sel_done = 1'b0;
		for (int j = 0; j < MAX_ITEMS; j++) begin
			if (!step_sel_done && !mask_q[j]) begin
				step_delta    = delta_q[j];
				step_sel_done = 1'b1;
			end
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg.valid) begin
			target_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_ITEMS; k++) begin
			if (cmd.load && loaded_q == LOADED_W'(k)) begin
				delta_q[k] <= value_ext - prefix_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			loaded_q     <= '0;
			ovf_q        <= 1'b0;
			mask_q       <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (store_room) begin
					prefix_q <= prefix_q + value_ext;
					loaded_q <= loaded_q + LOADED_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				mask_q       <= '0;
				sum_q        <= '0;
				count_q      <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.step) begin
				if (stat.hit) begin
					pend_valid_q <= 1'b1;
					count_q      <= count_q + COUNT_W'(1);
				end
				if (!stat.last_mask) begin
					mask_q <= mask_q + MASK_W'(1);
					sum_q  <= sum_q + step_delta;
				end
			end
			if (cmd.finish) begin
				prefix_q     <= '0;
				loaded_q     <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && stat.hit) begin
			pend_mask_q  <= mask_q;
			pend_count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_mask_q     <= pend_mask_q;
			out_found_q    <= 1'b1;
			out_count_q    <= pend_count_q;
			out_too_many_q <= ovf_q;
			out_last_q     <= 1'b0;
		end else if (cmd.finish) begin
			out_mask_q     <= pend_valid_q ? pend_mask_q : '0;
			out_found_q    <= pend_valid_q;
			out_count_q    <= pend_valid_q ? pend_count_q : '0;
			out_too_many_q <= ovf_q;
			out_last_q     <= 1'b1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.subset_mask = out_mask_q;
	assign results.found       = out_found_q;
	assign results.match_count = out_count_q;
	assign results.too_many    = out_too_many_q;
	assign results.last_result = out_last_q;

endmodule

FILE: design/subset_sum_matcher.sv
// Flow: an element is stored as it is accepted; the item marked last starts a walk
// of 2^n subset masks, one mask per cycle in the single running-sum adder while no
// second match waits on the result channel, then the final report once it is free.
// Items of a new set are accepted only in the load phase, not during a walk or report.
// Reset: arst_n clears the target sum, the element count and all control state.
// ----------------------------------------------------------------------------
// subset_sum_matcher
// Collects a set of signed values and reports every subset that sums to the
// configured target, in binary mask order.
// ----------------------------------------------------------------------------
module subset_sum_matcher import ssm_pkg::*; #(
	parameter int MAX_ITEMS  = 6,
	parameter int VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ssm_item_if.sink     items,
	ssm_cfg_if.sink      cfg,
	ssm_result_if.source results
);

	ssm_cmd_t  cmd;
	ssm_stat_t stat;

	ssm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_is_last (items.is_last),
		.in_ready   (items.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	ssm_datapath #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.item_value (items.item_value),
		.cfg        (cfg),
		.results    (results)
	);

endmodule
